### design/ps2mct_pkg.sv
// Shared types, constants and the per-axis cursor move function
// for the PS/2 mouse cursor tracker. No dependencies.
`timescale 1ns / 1ps

package ps2mct_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COORD_W = 12;

   localparam logic [COORD_W-1:0] STEP_PIXELS   = COORD_W'(6);
   localparam logic [COORD_W-1:0] EDGE_BACKOFF  = COORD_W'(15);
   localparam logic [COORD_W-1:0] WIDTH_RESET   = COORD_W'(640);
   localparam logic [COORD_W-1:0] HEIGHT_RESET  = COORD_W'(480);

   // status byte bit positions
   localparam int unsigned BIT_LEFT   = 0;
   localparam int unsigned BIT_RIGHT  = 1;
   localparam int unsigned BIT_MIDDLE = 2;
   localparam int unsigned BIT_SYNC   = 3;
   localparam int unsigned BIT_X_SIGN = 4;
   localparam int unsigned BIT_Y_SIGN = 5;
   localparam int unsigned BIT_X_OVF  = 6;
   localparam int unsigned BIT_Y_OVF  = 7;

   typedef enum logic {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      POS_STATUS = 2'd0,
      POS_X      = 2'd1,
      POS_Y      = 2'd2
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] mouse_byte;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] cursor_x;
      logic [COORD_W-1:0] cursor_y;
      logic               left_button;
      logic               right_button;
      logic               middle_button;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } beat_type;

   typedef struct packed {
      logic      take;
      phase_type phase;
   } core_status_type;

   function automatic logic [COORD_W-1:0] move_axis(
      input logic [COORD_W-1:0] pos,
      input logic               dec,
      input logic               inc,
      input logic [COORD_W-1:0] limit
   );
      logic [COORD_W:0]   nxt;
      logic               under;
      logic [COORD_W-1:0] result;
      under = dec && (pos < STEP_PIXELS);
      if (dec) begin
         nxt = {1'b0, pos} - {1'b0, STEP_PIXELS};
      end else if (inc) begin
         nxt = {1'b0, pos} + {1'b0, STEP_PIXELS};
      end else begin
         nxt = {1'b0, pos};
      end
      if (under) begin
         result = '0;
      end else if (nxt > {1'b0, limit}) begin
         result = (limit < EDGE_BACKOFF) ? '0 : limit - EDGE_BACKOFF;
      end else begin
         result = nxt[COORD_W-1:0];
      end
      return result;
   endfunction

endpackage

### design/ps2mct_if.sv
// Valid/ready channel carrying one payload beat.
// Payload type is set per instance; no other dependencies.
`timescale 1ns / 1ps

interface ps2mct_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### design/ps2mct_input_reg.sv
// Input register stage: holds one mouse byte beat until the core takes it.
// Depends on ps2mct_pkg and ps2mct_if.
`timescale 1ns / 1ps

module ps2mct_input_reg (
   input  logic                 clock,
   input  logic                 reset,
   ps2mct_if.sink               req_chan,
   input  logic                 take,
   output ps2mct_pkg::beat_type beat
);
   import ps2mct_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = req_chan.payload.mouse_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign beat.valid = valid_ff;
   assign beat.data  = data_ff;

endmodule

### design/ps2mct_core.sv
// Packet assembly, cursor update with clamping, limit registers and result register.
// Depends on ps2mct_pkg and ps2mct_if.
`timescale 1ns / 1ps

module ps2mct_core (
   input  logic                             clock,
   input  logic                             reset,
   input  ps2mct_pkg::beat_type             beat,
   output logic                             take,
   ps2mct_if.source                         rsp_chan,
   input  logic                             csr_wr_en,
   input  ps2mct_pkg::csr_index_type        csr_index,
   input  logic [ps2mct_pkg::COORD_W-1:0]   csr_wr_data,
   output ps2mct_pkg::core_status_type      status
);
   import ps2mct_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [BYTE_W-1:0]  stat_ff, stat_in;
   logic [BYTE_W-1:0]  xbyte_ff, xbyte_in;
   logic [COORD_W-1:0] pos_x_ff, pos_x_in;
   logic [COORD_W-1:0] pos_y_ff, pos_y_in;
   logic [COORD_W-1:0] width_ff, width_in;
   logic [COORD_W-1:0] height_ff, height_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               out_free;
   logic               produce;
   logic [COORD_W-1:0] new_x, new_y;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign produce  = (phase_ff == POS_Y) && !stat_ff[BIT_X_OVF] && !stat_ff[BIT_Y_OVF];
   assign take     = beat.valid && (!produce || out_free);

   assign new_x = move_axis(pos_x_ff, stat_ff[BIT_X_SIGN],
                            !stat_ff[BIT_X_SIGN] && (xbyte_ff != '0), width_ff);
   assign new_y = move_axis(pos_y_ff, !stat_ff[BIT_Y_SIGN] && (beat.data != '0),
                            stat_ff[BIT_Y_SIGN], height_ff);

   always_comb begin
      phase_in     = phase_ff;
      stat_in      = stat_ff;
      xbyte_in     = xbyte_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (take) begin
         unique case (phase_ff)
            POS_STATUS: begin
               if (beat.data[BIT_SYNC]) begin
                  stat_in  = beat.data;
                  phase_in = POS_X;
               end
            end
            POS_X: begin
               xbyte_in = beat.data;
               phase_in = POS_Y;
            end
            POS_Y: begin
               phase_in = POS_STATUS;
               if (produce) begin
                  pos_x_in                    = new_x;
                  pos_y_in                    = new_y;
                  rsp_valid_in                = 1'b1;
                  rsp_data_in.cursor_x        = new_x;
                  rsp_data_in.cursor_y        = new_y;
                  rsp_data_in.left_button     = stat_ff[BIT_LEFT];
                  rsp_data_in.right_button    = stat_ff[BIT_RIGHT];
                  rsp_data_in.middle_button   = stat_ff[BIT_MIDDLE];
               end
            end
            default: begin
               phase_in = POS_STATUS;
            end
         endcase
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  width_in  = csr_wr_data;
            CSR_SCREEN_HEIGHT: height_in = csr_wr_data;
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= POS_STATUS;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stat_ff     <= stat_in;
      xbyte_ff    <= xbyte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;
   assign status.take      = take;
   assign status.phase     = phase_ff;

endmodule

### design/ps2_mouse_cursor_tracker.sv
// PS/2 mouse cursor tracker, top level: one mouse byte per beat in,
// one cursor/button beat out per valid three-byte packet.
// The third byte waits in the input register until the core loads the result register.
// One byte per cycle unless rsp_chan stalls, set by the single input and result registers.
// Reset: clears cursor to 0,0, limits to 640x480 and packet phase; bytes held are not reset.
// Depends on ps2mct_pkg, ps2mct_if, ps2mct_input_reg and ps2mct_core.
`timescale 1ns / 1ps

module ps2_mouse_cursor_tracker (
   input  logic                           clock,
   input  logic                           reset,
   ps2mct_if.sink                         req_chan,
   ps2mct_if.source                       rsp_chan,
   input  logic                           csr_wr_en,
   input  ps2mct_pkg::csr_index_type      csr_index,
   input  logic [ps2mct_pkg::COORD_W-1:0] csr_wr_data
);
   import ps2mct_pkg::*;

   beat_type        beat;
   logic            take;
   core_status_type core_status;

   ps2mct_input_reg u_input_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .beat     (beat)
   );

   ps2mct_core u_core (
      .clock       (clock),
      .reset       (reset),
      .beat        (beat),
      .take        (take),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .status      (core_status)
   );

`ifndef SYNTHESIS
   a_reset_clears_rsp : assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid set after reset");

   a_rsp_after_third : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(core_status.phase == POS_Y))
      else $error("result raised outside third packet byte");

   a_phase_wraps : assert property (@(posedge clock) disable iff (reset)
      core_status.take && (core_status.phase == POS_Y) |=> core_status.phase == POS_STATUS)
      else $error("packet phase did not wrap after third byte");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench for ps2_mouse_cursor_tracker: streams mouse bytes,
// predicts cursor/button beats in step, checks every result beat.
// Depends on ps2mct_pkg, ps2mct_if and the ps2_mouse_cursor_tracker RTL.
`timescale 1ns / 1ps

module testbench;
   import ps2mct_pkg::*;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   csr_index_type       csr_index;
   logic [COORD_W-1:0]  csr_wr_data;

   ps2mct_if #(.payload_type(req_type)) req_chan ();
   ps2mct_if #(.payload_type(rsp_type)) rsp_chan ();

   ps2_mouse_cursor_tracker u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   logic [BYTE_W-1:0]  pending_mouse_bytes[$];
   rsp_type            expected_cursor[$];
   int                 send_idle_pct;
   int                 recv_stall_pct;
   int                 fail_count = 0;

   // predictor state
   logic [COORD_W-1:0] width_limit  = WIDTH_RESET;
   logic [COORD_W-1:0] height_limit = HEIGHT_RESET;
   logic [COORD_W-1:0] cur_x = '0;
   logic [COORD_W-1:0] cur_y = '0;
   phase_type          byte_pos = POS_STATUS;
   logic [BYTE_W-1:0]  status_byte;
   logic [BYTE_W-1:0]  x_byte;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [COORD_W-1:0] step_axis(
      input logic [COORD_W-1:0] pos,
      input int                 dir,
      input logic [COORD_W-1:0] limit
   );
      int nxt;
      nxt = int'(pos) + dir * int'(STEP_PIXELS);
      if (nxt < 0) return '0;
      if (nxt > int'(limit)) return (limit < EDGE_BACKOFF) ? '0 : limit - EDGE_BACKOFF;
      return nxt[COORD_W-1:0];
   endfunction

   function automatic void track_mouse_byte(input logic [BYTE_W-1:0] b);
      int      x_dir;
      int      y_dir;
      rsp_type beat;
      case (byte_pos)
         POS_STATUS: begin
            if (!b[BIT_SYNC]) return;
            status_byte = b;
            byte_pos = POS_X;
         end
         POS_X: begin
            x_byte = b;
            byte_pos = POS_Y;
         end
         default: begin
            byte_pos = POS_STATUS;
            if (status_byte[BIT_X_OVF] || status_byte[BIT_Y_OVF]) return;
            x_dir = status_byte[BIT_X_SIGN] ? -1 : ((x_byte != 0) ? 1 : 0);
            y_dir = status_byte[BIT_Y_SIGN] ? -1 : ((b != 0) ? 1 : 0);
            cur_x = step_axis(cur_x, x_dir, width_limit);
            cur_y = step_axis(cur_y, -y_dir, height_limit);
            beat.cursor_x      = cur_x;
            beat.cursor_y      = cur_y;
            beat.left_button   = status_byte[BIT_LEFT];
            beat.right_button  = status_byte[BIT_RIGHT];
            beat.middle_button = status_byte[BIT_MIDDLE];
            expected_cursor.push_back(beat);
         end
      endcase
   endfunction

   always @(posedge clock) begin : byte_driver
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            track_mouse_byte(req_chan.payload.mouse_byte);
            void'(pending_mouse_bytes.pop_front());
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_mouse_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_chan.valid   <= 1'b1;
               req_chan.payload <= req_type'(pending_mouse_bytes[0]);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : cursor_monitor
      rsp_type want;
      rsp_type got;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            if (expected_cursor.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected cursor beat: x=%0d y=%0d buttons l/r/m=%b%b%b",
                           got.cursor_x, got.cursor_y, got.left_button,
                           got.right_button, got.middle_button);
            end else begin
               want = expected_cursor.pop_front();
               if (got.cursor_x !== want.cursor_x || got.cursor_y !== want.cursor_y ||
                   got.left_button !== want.left_button ||
                   got.right_button !== want.right_button ||
                   got.middle_button !== want.middle_button) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"cursor mismatch: expected x=%0d y=%0d lrm=%b%b%b, ",
                               "got x=%0d y=%0d lrm=%b%b%b"},
                              want.cursor_x, want.cursor_y, want.left_button,
                              want.right_button, want.middle_button,
                              got.cursor_x, got.cursor_y, got.left_button,
                              got.right_button, got.middle_button);
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic queue_packet(input logic [7:0] status, input logic [7:0] x,
                               input logic [7:0] y);
      pending_mouse_bytes.push_back(status);
      pending_mouse_bytes.push_back(x);
      pending_mouse_bytes.push_back(y);
   endtask

   // dir is the axis direction as encoded in the packet: -1, 0 or +1
   function automatic void pick_axis(input int dir, output logic sign,
                                     output logic [7:0] mag);
      sign = (dir < 0);
      if (dir < 0) mag = 8'($urandom_range(255));
      else if (dir > 0) mag = 8'($urandom_range(255, 1));
      else mag = '0;
   endfunction

   task automatic wait_for_idle();
      while (pending_mouse_bytes.size() != 0 || req_chan.valid || expected_cursor.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_limits(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_SCREEN_WIDTH;
      csr_wr_data <= w;
      @(posedge clock);
      csr_index   <= CSR_SCREEN_HEIGHT;
      csr_wr_data <= h;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      width_limit  = w;
      height_limit = h;
   endtask

   // x_bias/y_bias steer the cursor (screen terms) so the edges get reached
   task automatic fill_random_phase(input int n_items, input int x_bias, input int y_bias);
      int          queued;
      int          roll;
      int          xd;
      int          yd;
      logic        xs;
      logic        ys;
      logic [7:0]  xv;
      logic [7:0]  yv;
      logic [7:0]  status;
      queued = 0;
      @(negedge clock);
      while (queued < n_items) begin
         roll = $urandom_range(99);
         if (roll < 6) begin
            pending_mouse_bytes.push_back(8'($urandom_range(255)));
            queued++;
         end else if (roll < 10) begin
            // broken packet: status and at most one more byte
            status = 8'($urandom_range(255));
            status[BIT_SYNC] = 1'b1;
            pending_mouse_bytes.push_back(status);
            queued++;
            if ($urandom_range(1)) begin
               pending_mouse_bytes.push_back(8'($urandom_range(255)));
               queued++;
            end
         end else begin
            xd = ($urandom_range(99) < 75) ? x_bias : int'($urandom_range(2)) - 1;
            yd = ($urandom_range(99) < 75) ? y_bias : int'($urandom_range(2)) - 1;
            pick_axis(xd, xs, xv);
            pick_axis(-yd, ys, yv);
            status = 8'($urandom_range(255));
            status[BIT_SYNC]   = 1'b1;
            status[BIT_X_SIGN] = xs;
            status[BIT_Y_SIGN] = ys;
            if ($urandom_range(99) >= 8) begin
               status[BIT_X_OVF] = 1'b0;
               status[BIT_Y_OVF] = 1'b0;
            end
            queue_packet(status, xv, yv);
            queued += 3;
         end
      end
   endtask

   initial begin : stimulus
      int w_list [6] = '{4095, 16, 3, 150, 0, 15};
      int h_list [6] = '{4095, 16, 0, 120, 0, 14};
      int xb_list[6] = '{1, 0, 1, 1, -1, 0};
      int yb_list[6] = '{1, 0, -1, 1, -1, 1};
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_SCREEN_WIDTH;
      csr_wr_data      = '0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      send_idle_pct    = 7;
      recv_stall_pct   = 60;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // drop stray bytes, then edge and discard cases at the reset limits
      pending_mouse_bytes.push_back(8'h00);
      pending_mouse_bytes.push_back(8'hF7);
      queue_packet(8'h08, 8'h00, 8'h00);
      queue_packet(8'h1F, 8'h00, 8'hFF);
      queue_packet(8'h28, 8'h01, 8'h80);
      queue_packet(8'h48, 8'h7F, 8'h7F);
      queue_packet(8'h88, 8'h01, 8'h01);
      queue_packet(8'hFF, 8'hFF, 8'hFF);
      queue_packet(8'h09, 8'hFF, 8'h00);
      queue_packet(8'h0A, 8'h00, 8'h00);

      for (int p = 0; p < 6; p++) begin
         wait_for_idle();
         if (p < 2) begin
            send_idle_pct  = 7;
            recv_stall_pct = 60;
         end else if (p < 4) begin
            send_idle_pct  = 60;
            recv_stall_pct = 7;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         if (p == 4) begin
            w_list[p] = $urandom_range(4095, 16);
            h_list[p] = $urandom_range(4095, 16);
         end
         write_limits(COORD_W'(w_list[p]), COORD_W'(h_list[p]));
         fill_random_phase(175, xb_list[p], yb_list[p]);
      end

      wait_for_idle();
      repeat (10) @(negedge clock);
      if (expected_cursor.size() != 0) begin
         fail_count++;
         $display("%0d expected cursor beats never arrived", expected_cursor.size());
      end
      if (fail_count == 0) begin
         $display("ps2_mouse_cursor_tracker regression: pass");
      end else begin
         $display("ps2_mouse_cursor_tracker regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("ps2_mouse_cursor_tracker regression: fail");
      $finish;
   end

endmodule

### files.f
design/ps2mct_pkg.sv
design/ps2mct_if.sv
design/ps2mct_input_reg.sv
design/ps2mct_core.sv
design/ps2_mouse_cursor_tracker.sv
verif/testbench.sv
